[rtl/lhr_pkg.sv]
package lhr_pkg;

    // Number of histogram buckets, and the width of every event counter.
    localparam int BUCKET_COUNT = 7;
    localparam int COUNT_WIDTH  = 32;

    // Number of bound registers on the configuration port.
    localparam int BOUND_REGS = 6;
    localparam int GAP_WIDTH  = 32;
    localparam int OUT_WIDTH  = 32;
    localparam int INDEX_WIDTH = 3;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int PICK_WIDTH = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

    typedef logic [GAP_WIDTH-1:0]   t_gap;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [PICK_WIDTH-1:0]  t_pick;
    typedef logic [OUT_WIDTH-1:0]   t_out;
    typedef t_gap [BOUND_REGS-1:0]  t_bounds;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_BOUND_ONE   = 3'd0,
        CFG_BOUND_TWO   = 3'd1,
        CFG_BOUND_THREE = 3'd2,
        CFG_BOUND_FOUR  = 3'd3,
        CFG_BOUND_FIVE  = 3'd4,
        CFG_BOUND_SIX   = 3'd5
    } t_cfg_index;

    localparam t_gap BOUND_RESET [BOUND_REGS] = '{
        32'd1000, 32'd5000, 32'd16000, 32'd50000, 32'd100000, 32'd500000
    };

    // Saturating increment of an event counter.
    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : t_count'(v + t_count'(1));
    endfunction

    // A reported count is limited to the 32-bit output field.
    function automatic t_out clip_count(input t_count v);
        logic [COUNT_WIDTH+OUT_WIDTH-1:0] wide;
        wide = {{OUT_WIDTH{1'b0}}, v};
        if (wide > {{COUNT_WIDTH{1'b0}}, {OUT_WIDTH{1'b1}}}) begin
            return '1;
        end
        return wide[OUT_WIDTH-1:0];
    endfunction

endpackage

[rtl/lhr_classify.sv]
module lhr_classify (
    input  lhr_pkg::t_gap    i_gap,
    input  lhr_pkg::t_bounds i_bounds,
    output lhr_pkg::t_pick   o_pick
);

    // The lowest bucket whose bound exceeds the gap wins; scanning from the
    // top down lets each lower match override the ones above it.
    always_comb begin
        o_pick = lhr_pkg::t_pick'(lhr_pkg::BUCKET_COUNT - 1);
        for (int i = lhr_pkg::BUCKET_COUNT - 2; i >= 0; i--) begin
            if (i_gap < i_bounds[i]) begin
                o_pick = lhr_pkg::t_pick'(i);
            end
        end
    end

endmodule

[rtl/latency_histogram_recorder_top.sv]
// Latency histogram with running maximum. Each request on the slave stream
// carries one gap in microseconds; the block sorts it into the first of the
// buckets whose exclusive upper bound (bound registers 0 to 5) exceeds it,
// or into the last bucket, and answers with one result: the bucket index,
// that bucket's new count, the total count and the largest gap so far.
// Counters saturate and are cleared by reset. The block takes one request
// per clock unless the result stream stalls. A result is valid once it is
// registered: the bucket compare and the counter update both sit between the
// input register and the result register. Bounds must only be written while
// no request is in flight, since a request is compared against the bounds
// while it waits in the input register.
module latency_histogram_recorder_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [31:0]  i_s_tdata,   // [31:0] gap_micros
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [2:0] bucket_index, [34:3] bucket_total, [66:35] item_total,
    // [98:67] largest_gap, [103:99] zero
    output logic [103:0] o_m_tdata,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    lhr_pkg::t_bounds r_bounds;

    logic            r_in_valid;
    lhr_pkg::t_gap   r_gap;
    lhr_pkg::t_pick  n_pick;

    lhr_pkg::t_count r_item_counter;
    lhr_pkg::t_gap   r_peak_gap;
    lhr_pkg::t_count r_bucket_counters [lhr_pkg::BUCKET_COUNT];

    logic            r_out_valid;
    logic [2:0]      r_out_index;
    lhr_pkg::t_out   r_out_bucket;
    lhr_pkg::t_out   r_out_total;
    lhr_pkg::t_gap   r_out_peak;

    logic            advance;
    logic            in_accept;
    lhr_pkg::t_count n_item_counter;
    lhr_pkg::t_gap   n_peak_gap;
    lhr_pkg::t_count n_bucket_count;

    // Bound registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lhr_pkg::BOUND_REGS; i++) begin
                r_bounds[i] <= lhr_pkg::BOUND_RESET[i];
            end
        end else if (i_cfg_we) begin
            unique case (lhr_pkg::t_cfg_index'(i_cfg_index))
                lhr_pkg::CFG_BOUND_ONE:   r_bounds[0] <= i_cfg_data;
                lhr_pkg::CFG_BOUND_TWO:   r_bounds[1] <= i_cfg_data;
                lhr_pkg::CFG_BOUND_THREE: r_bounds[2] <= i_cfg_data;
                lhr_pkg::CFG_BOUND_FOUR:  r_bounds[3] <= i_cfg_data;
                lhr_pkg::CFG_BOUND_FIVE:  r_bounds[4] <= i_cfg_data;
                lhr_pkg::CFG_BOUND_SIX:   r_bounds[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lhr_classify u_classify (
        .i_gap    (r_gap),
        .i_bounds (r_bounds),
        .o_pick   (n_pick)
    );

    // The result stage moves when its register is empty or being drained.
    assign advance    = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || advance;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_gap <= i_s_tdata;
        end
    end

    always_comb begin
        n_item_counter = lhr_pkg::sat_inc(r_item_counter);
        n_peak_gap     = (r_gap > r_peak_gap) ? r_gap : r_peak_gap;
        n_bucket_count = lhr_pkg::sat_inc(r_bucket_counters[n_pick]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_counter <= '0;
            r_peak_gap     <= '0;
            for (int i = 0; i < lhr_pkg::BUCKET_COUNT; i++) begin
                r_bucket_counters[i] <= '0;
            end
        end else if (r_in_valid && advance) begin
            r_item_counter            <= n_item_counter;
            r_peak_gap                <= n_peak_gap;
            r_bucket_counters[n_pick] <= n_bucket_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid && advance) begin
            r_out_index  <= 3'(n_pick);
            r_out_bucket <= lhr_pkg::clip_count(n_bucket_count);
            r_out_total  <= lhr_pkg::clip_count(n_item_counter);
            r_out_peak   <= n_peak_gap;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_peak, r_out_total, r_out_bucket, r_out_index};

    // Every result counts at least its own request.
    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[66:35] != 32'd0))
        else $error("item total is zero on a valid result");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] < 3'(lhr_pkg::BUCKET_COUNT)))
        else $error("bucket index out of range");

    // One bucket can never hold more than all requests together.
    a_bucket_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[34:3] <= o_m_tdata[66:35]))
        else $error("bucket count exceeds item total");

    a_peak_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready) ##1 o_m_tvalid
            |-> (o_m_tdata[98:67] >= $past(o_m_tdata[98:67])))
        else $error("largest gap decreased between results");

endmodule
